FILE: hw/rtl/isbe_pkg.sv
// Shared widths, register indexes and reset values for the intensity stereo band encoder.
package isbe_pkg;

   // Widths of the band state and of the result fields.
   localparam int ENERGY_W = 64;
   localparam int GAIN_W   = 32;
   localparam int POS_W    = 8;
   localparam int BAND_W   = 6;
   localparam int MUL_W    = 32;

   // Configuration register indexes, taken from address bit 2.
   localparam logic CSR_MIN_BAND_LONG  = 1'b0;
   localparam logic CSR_MIN_BAND_SHORT = 1'b1;

   // Reset values of the configuration registers.
   localparam logic [5:0] MIN_BAND_LONG_RESET  = 6'd28;
   localparam logic [3:0] MIN_BAND_SHORT_RESET = 4'd8;

endpackage

FILE: hw/rtl/isbe_gain.sv
// Band gain unit: bit-serial divide followed by a bit-serial square root.
module isbe_gain import isbe_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [ENERGY_W-1:0] energy_left,
   input  logic [ENERGY_W-1:0] energy_sum,
   output logic                busy,
   output logic [GAIN_W-1:0]   gain
);

   localparam int DIV_W  = ENERGY_W + 2 * FRAC_BITS;
   localparam int CNT_W  = $clog2(DIV_W + 1);
   localparam int ROOT_STEPS = GAIN_W;

   typedef enum logic [2:0] {
      G_IDLE = 3'b001,
      G_DIV  = 3'b010,
      G_SQRT = 3'b100
   } gain_state_type;

   gain_state_type        state_ff, state_in;
   logic [DIV_W-1:0]      quo_ff, quo_in;
   logic [ENERGY_W-1:0]   rem_ff, rem_in;
   logic [ENERGY_W:0]     den_ff, den_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [GAIN_W-1:0]     root_ff, root_in;
   logic [GAIN_W+3:0]     srem_ff, srem_in;
   logic [GAIN_W-1:0]     gain_ff, gain_in;

   logic [ENERGY_W:0]     div_shift;
   logic [ENERGY_W+1:0]   div_diff;
   logic                  div_ge;
   logic [GAIN_W+3:0]     sq_shift;
   logic [GAIN_W+3:0]     sq_trial;
   logic                  sq_ge;

   // One restoring divide step: the dividend leaves at the top, quotient bits enter below.
   always_comb begin
      div_shift = {rem_ff, quo_ff[DIV_W-1]};
      div_diff  = {1'b0, div_shift} - {1'b0, den_ff};
      div_ge    = ~div_diff[ENERGY_W+1];
   end

   // One square root step on two quotient bits at a time.
   always_comb begin
      sq_shift = {srem_ff[GAIN_W+1:0], quo_ff[ENERGY_W-1:ENERGY_W-2]};
      sq_trial = {2'b00, root_ff, 2'b01};
      sq_ge    = (sq_shift >= sq_trial);
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      cnt_in   = cnt_ff;
      root_in  = root_ff;
      srem_in  = srem_ff;
      gain_in  = gain_ff;
      case (state_ff)
         G_IDLE: begin
            if (start) begin
               quo_in   = {energy_left, {(2 * FRAC_BITS){1'b0}}};
               den_in   = {1'b0, energy_sum} + {{ENERGY_W{1'b0}}, 1'b1};
               rem_in   = '0;
               cnt_in   = CNT_W'(DIV_W);
               state_in = G_DIV;
            end
         end
         G_DIV: begin
            rem_in = div_ge ? div_diff[ENERGY_W-1:0] : div_shift[ENERGY_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], div_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               cnt_in   = CNT_W'(ROOT_STEPS);
               root_in  = '0;
               srem_in  = '0;
               state_in = G_SQRT;
            end
         end
         G_SQRT: begin
            srem_in = sq_ge ? (sq_shift - sq_trial) : sq_shift;
            root_in = {root_ff[GAIN_W-2:0], sq_ge};
            quo_in  = {quo_ff[DIV_W-1:ENERGY_W], quo_ff[ENERGY_W-3:0], 2'b00};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               // A quotient of 2^64 or more has a root beyond the gain range.
               gain_in  = (|quo_ff[DIV_W-1:ENERGY_W]) ? '1 : {root_ff[GAIN_W-2:0], sq_ge};
               state_in = G_IDLE;
            end
         end
         default: begin
            state_in = G_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= G_IDLE;
         gain_ff  <= '0;
      end else begin
         state_ff <= state_in;
         gain_ff  <= gain_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
      root_ff <= root_in;
      srem_ff <= srem_in;
   end

   assign busy = (state_ff != G_IDLE);
   assign gain = gain_ff;

endmodule

FILE: hw/rtl/isbe_pos.sv
// Intensity position unit: normalize, exact fourth powers by limbs, threshold compares.
module isbe_pos import isbe_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [ENERGY_W-1:0] energy_left,
   input  logic [ENERGY_W-1:0] energy_right,
   output logic                busy,
   output logic [POS_W-1:0]    position
);

   typedef enum logic [3:0] {
      P_IDLE = 4'b0001,
      P_NORM = 4'b0010,
      P_SQ   = 4'b0100,
      P_CMP  = 4'b1000
   } pos_state_type;

   pos_state_type      state_ff, state_in;
   logic [63:0]        ln_ff, ln_in, rn_ff, rn_in;
   logic [5:0]         lzl_ff, lzl_in, lzr_ff, lzr_in;
   logic [127:0]       src_ff, src_in;
   logic [255:0]       dst_ff, dst_in;
   logic [255:0]       l4_ff, l4_in;
   logic [63:0]        mul_ff, mul_in;
   logic [67:0]        acc_ff, acc_in;
   logic [2:0]         col_ff, col_in;
   logic [1:0]         idx_ff, idx_in;
   logic               ph_ff, ph_in;
   logic [1:0]         step_ff, step_in;
   logic [1:0]         kc_ff, kc_in;
   logic [2:0]         hits_ff, hits_in;
   logic [POS_W-1:0]   pos_ff, pos_in;

   logic [3:0]   n_m1, col4, hi_idx, col_nx, lo_nx, last_col, j4;
   logic [67:0]  acc_sum;
   logic [255:0] dst_next;
   logic [1:0]   lsh, rsh;
   logic [258:0] cmp_a, cmp_b;
   logic         cmp_ge;
   logic [2:0]   hits_tot;
   logic [9:0]   pos_raw;

   function automatic logic [31:0] limb_of(input logic [127:0] v, input logic [1:0] s);
      logic [31:0] r;
      case (s)
         2'd0:    r = v[31:0];
         2'd1:    r = v[63:32];
         2'd2:    r = v[95:64];
         default: r = v[127:96];
      endcase
      return r;
   endfunction

   // Column bounds of the schoolbook square: two or four source limbs.
   // The last product column also stores the final carry as the top limb.
   always_comb begin
      n_m1     = step_ff[0] ? 4'd3 : 4'd1;
      col4     = {1'b0, col_ff};
      hi_idx   = (col4 > n_m1) ? n_m1 : col4;
      col_nx   = col4 + 4'd1;
      lo_nx    = (col_nx >= n_m1) ? (col_nx - n_m1) : 4'd0;
      last_col = 4'(n_m1 << 1);
      j4       = col4 - {2'b00, idx_ff};
      acc_sum  = acc_ff + {4'b0000, mul_ff};
      dst_next = dst_ff;
      dst_next[col_ff * 32 +: 32] = acc_sum[31:0];
      if (col4 == last_col) begin
         dst_next[col_nx[2:0] * 32 +: 32] = acc_sum[63:32];
      end
   end

   // Threshold compare of the fourth powers, scaled by 8, 2, 1/2 and 1/8.
   always_comb begin
      case (kc_ff)
         2'd0:    begin lsh = 2'd3; rsh = 2'd0; end
         2'd1:    begin lsh = 2'd1; rsh = 2'd0; end
         2'd2:    begin lsh = 2'd0; rsh = 2'd1; end
         default: begin lsh = 2'd0; rsh = 2'd3; end
      endcase
      cmp_a    = {3'b000, l4_ff} << lsh;
      cmp_b    = {3'b000, dst_ff} << rsh;
      cmp_ge   = (cmp_a >= cmp_b);
      hits_tot = hits_ff + {2'b00, cmp_ge};
      pos_raw  = ((10'(lzr_ff) - 10'(lzl_ff)) << 1) + 10'(hits_tot) - 10'd2;
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      ln_in    = ln_ff;
      rn_in    = rn_ff;
      lzl_in   = lzl_ff;
      lzr_in   = lzr_ff;
      src_in   = src_ff;
      dst_in   = dst_ff;
      l4_in    = l4_ff;
      mul_in   = mul_ff;
      acc_in   = acc_ff;
      col_in   = col_ff;
      idx_in   = idx_ff;
      ph_in    = ph_ff;
      step_in  = step_ff;
      kc_in    = kc_ff;
      hits_in  = hits_ff;
      pos_in   = pos_ff;
      case (state_ff)
         P_IDLE: begin
            if (start) begin
               if (energy_left == '0 && energy_right == '0) begin
                  pos_in = 8'sd0;
               end else if (energy_right == '0) begin
                  pos_in = 8'sd127;
               end else if (energy_left == '0) begin
                  pos_in = 8'h80;
               end else begin
                  ln_in    = energy_left;
                  rn_in    = energy_right;
                  lzl_in   = '0;
                  lzr_in   = '0;
                  state_in = P_NORM;
               end
            end
         end
         P_NORM: begin
            if (ln_ff[63] && rn_ff[63]) begin
               src_in   = {64'd0, ln_ff};
               step_in  = 2'd0;
               col_in   = '0;
               idx_in   = '0;
               ph_in    = 1'b0;
               acc_in   = '0;
               state_in = P_SQ;
            end else begin
               if (!ln_ff[63]) begin
                  ln_in  = ln_ff << 1;
                  lzl_in = lzl_ff + 6'd1;
               end
               if (!rn_ff[63]) begin
                  rn_in  = rn_ff << 1;
                  lzr_in = lzr_ff + 6'd1;
               end
            end
         end
         P_SQ: begin
            if (!ph_ff) begin
               mul_in = limb_of(src_ff, idx_ff) * limb_of(src_ff, j4[1:0]);
               ph_in  = 1'b1;
            end else begin
               ph_in = 1'b0;
               if ({2'b00, idx_ff} == hi_idx) begin
                  dst_in = dst_next;
                  acc_in = acc_sum >> 32;
                  idx_in = lo_nx[1:0];
                  col_in = col_nx[2:0];
                  if (col4 == last_col) begin
                     col_in  = '0;
                     idx_in  = '0;
                     acc_in  = '0;
                     step_in = step_ff + 2'd1;
                     case (step_ff)
                        2'd0: src_in = dst_next[127:0];
                        2'd1: begin
                           l4_in  = dst_next;
                           src_in = {64'd0, rn_ff};
                        end
                        2'd2: src_in = dst_next[127:0];
                        default: begin
                           kc_in    = '0;
                           hits_in  = '0;
                           state_in = P_CMP;
                        end
                     endcase
                  end
               end else begin
                  acc_in = acc_sum;
                  idx_in = idx_ff + 2'd1;
               end
            end
         end
         P_CMP: begin
            hits_in = hits_tot;
            kc_in   = kc_ff + 2'd1;
            if (kc_ff == 2'd3) begin
               if ($signed(pos_raw) > 10'sd127) begin
                  pos_in = 8'sd127;
               end else if ($signed(pos_raw) < -10'sd128) begin
                  pos_in = 8'h80;
               end else begin
                  pos_in = pos_raw[7:0];
               end
               state_in = P_IDLE;
            end
         end
         default: begin
            state_in = P_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
      ln_ff   <= ln_in;
      rn_ff   <= rn_in;
      lzl_ff  <= lzl_in;
      lzr_ff  <= lzr_in;
      src_ff  <= src_in;
      dst_ff  <= dst_in;
      l4_ff   <= l4_in;
      mul_ff  <= mul_in;
      acc_ff  <= acc_in;
      col_ff  <= col_in;
      idx_ff  <= idx_in;
      ph_ff   <= ph_in;
      step_ff <= step_in;
      kc_ff   <= kc_in;
      hits_ff <= hits_in;
   end

   assign busy     = (state_ff != P_IDLE);
   assign position = pos_ff;

endmodule

FILE: hw/rtl/intensity_stereo_band_encoder.sv
// Top level of the intensity stereo band encoder: line sequencer, energies and result register.
//
// Requests carry one line pair with its mode. In measure mode the squares of left, right
// and left plus right are added to three saturating 64-bit energies over a shared 32x32
// multiplier; the sequencer stays busy until the three energies are updated.
// On the last line of a band the decision is made and two units run: the gain unit
// (64 + 2*GAIN_FRACTION_BITS divide steps, then 32 root steps) and the position unit
// (up to 64 normalize steps, limb products for four squarings, 4 compares). The decision
// result (kind 0) is loaded once both units are done and the result register is free.
// Measure lines other than the last issue no result.
// In apply mode one replaced line (kind 1) is made with one multiply and is loaded once
// the result register is free; the next request can enter after that.
// req_stall is high while a request is in work; one request is in work at a time.
// The result register lets the next request enter while a result waits; while rsp_stall
// is high that result holds and a new result waits inside the sequencer.
// Reset clears the energies, the gain, the band decision and the result valid flag, and
// loads the minimum band registers with 28 (long blocks) and 8 (short blocks).
module intensity_stereo_band_encoder import isbe_pkg::*; #(
   parameter int SAMPLE_BITS        = 24,
   parameter int GAIN_FRACTION_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic signed [SAMPLE_BITS-1:0] req_left_sample,
   input  logic signed [SAMPLE_BITS-1:0] req_right_sample,
   input  logic [BAND_W-1:0]             req_band_index,
   input  logic                          req_short_block,
   input  logic                          req_last_line,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_kind,
   output logic                          rsp_is_used,
   output logic signed [POS_W-1:0]       rsp_position,
   output logic signed [SAMPLE_BITS-1:0] rsp_new_left,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [2:0]                    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   localparam int S = SAMPLE_BITS;
   localparam logic [63:0] HALF    = 64'd1 << (GAIN_FRACTION_BITS - 1);
   localparam logic [63:0] NEG_MAX = 64'd1 << (S - 1);
   localparam logic [63:0] POS_MAX = NEG_MAX - 64'd1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SQ    = 4'b0010,
      ST_APPLY = 4'b0100,
      ST_BAND  = 4'b1000
   } enc_state_type;

   enc_state_type          state_ff, state_in;
   logic [2:0]             cnt_ff, cnt_in;
   logic [S-1:0]           l_ff, r_ff;
   logic [BAND_W-1:0]      band_ff;
   logic                   short_ff, last_ff;
   logic [ENERGY_W-1:0]    el_ff, el_in, er_ff, er_in, es_ff, es_in;
   logic                   active_ff, active_in;
   logic [63:0]            mul_ff;
   logic [5:0]             min_long_ff;
   logic [3:0]             min_short_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   kind_ff, kind_in;
   logic                   used_ff, used_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [S-1:0]           new_left_ff, new_left_in;

   logic                   accept, out_free, out_load, unit_start;
   logic                   gain_busy, pos_busy;
   logic [GAIN_W-1:0]      gain;
   logic [POS_W-1:0]       unit_pos;
   logic [S:0]             sum_w, ms_w;
   logic [S-1:0]           ml, mr;
   logic [32:0]            ms33;
   logic [MUL_W-1:0]       mul_a, mul_b;
   logic [ENERGY_W-1:0]    acc_tgt, acc_add;
   logic [ENERGY_W:0]      acc_sum;
   logic [ENERGY_W-1:0]    acc_res;
   logic [63:0]            prod64, mag, mag_c;
   logic [S-1:0]           applied;
   logic                   s_neg, band_hit;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_long_ff  <= MIN_BAND_LONG_RESET;
         min_short_ff <= MIN_BAND_SHORT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         if (csr_paddr[2] == CSR_MIN_BAND_LONG) begin
            min_long_ff <= csr_pwdata[5:0];
         end else begin
            min_short_ff <= csr_pwdata[3:0];
         end
      end
   end
   assign csr_prdata = (csr_paddr[2] == CSR_MIN_BAND_SHORT) ? {28'd0, min_short_ff}
                                                            : {26'd0, min_long_ff};
   assign csr_pready = 1'b1;

   // Magnitudes of the line pair and of its sum.
   always_comb begin
      sum_w = {l_ff[S-1], l_ff} + {r_ff[S-1], r_ff};
      s_neg = sum_w[S];
      ms_w  = s_neg ? ((~sum_w) + 1'b1) : sum_w;
      ml    = l_ff[S-1] ? ((~l_ff) + 1'b1) : l_ff;
      mr    = r_ff[S-1] ? ((~r_ff) + 1'b1) : r_ff;
      ms33  = 33'(ms_w);
   end

   // Shared multiplier operands.
   always_comb begin
      mul_a = ms33[31:0];
      mul_b = ms33[31:0];
      if (state_ff == ST_APPLY) begin
         mul_b = gain;
      end else begin
         case (cnt_ff)
            3'd0: begin
               mul_a = 32'(ml);
               mul_b = 32'(ml);
            end
            3'd1: begin
               mul_a = 32'(mr);
               mul_b = 32'(mr);
            end
            default: begin
               mul_a = ms33[31:0];
               mul_b = ms33[31:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
   end

   // Saturating energy adder, one accumulator per cycle.
   always_comb begin
      case (cnt_ff)
         3'd1:    acc_tgt = el_ff;
         3'd2:    acc_tgt = er_ff;
         default: acc_tgt = es_ff;
      endcase
      acc_add = (cnt_ff == 3'd3 && ms33[32]) ? '1 : mul_ff;
      acc_sum = {1'b0, acc_tgt} + {1'b0, acc_add};
      acc_res = acc_sum[ENERGY_W] ? '1 : acc_sum[ENERGY_W-1:0];
   end

   // Replaced line: scale, round half away from zero, saturate.
   always_comb begin
      prod64  = mul_ff + (ms33[32] ? {gain, 32'd0} : 64'd0);
      mag     = (prod64 + HALF) >> GAIN_FRACTION_BITS;
      if (s_neg) begin
         mag_c = (mag > NEG_MAX) ? NEG_MAX : mag;
      end else begin
         mag_c = (mag > POS_MAX) ? POS_MAX : mag;
      end
      applied = s_neg ? S'(64'd0 - mag_c) : S'(mag_c);
   end

   assign band_hit   = band_ff >= (short_ff ? {2'b00, min_short_ff} : min_long_ff);
   assign unit_start = (state_ff == ST_SQ) && (cnt_ff == 3'd4) && last_ff;

   // Line sequencer.
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      el_in       = el_ff;
      er_in       = er_ff;
      es_in       = es_ff;
      active_in   = active_ff;
      out_load    = 1'b0;
      kind_in     = kind_ff;
      used_in     = used_ff;
      pos_in      = pos_ff;
      new_left_in = new_left_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cnt_in   = '0;
               state_in = req_mode ? ST_APPLY : ST_SQ;
            end
         end
         ST_SQ: begin
            cnt_in = cnt_ff + 3'd1;
            case (cnt_ff)
               3'd1: el_in = acc_res;
               3'd2: er_in = acc_res;
               3'd3: es_in = acc_res;
               3'd4: begin
                  if (last_ff) begin
                     active_in = band_hit;
                     el_in     = '0;
                     er_in     = '0;
                     es_in     = '0;
                     state_in  = ST_BAND;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               default: ;
            endcase
         end
         ST_APPLY: begin
            if (cnt_ff == 3'd0) begin
               cnt_in = 3'd1;
            end else if (out_free) begin
               out_load    = 1'b1;
               kind_in     = 1'b1;
               used_in     = active_ff;
               pos_in      = '0;
               new_left_in = active_ff ? applied : l_ff;
               state_in    = ST_IDLE;
            end
         end
         ST_BAND: begin
            if (!gain_busy && !pos_busy && out_free) begin
               out_load    = 1'b1;
               kind_in     = 1'b0;
               used_in     = active_ff;
               pos_in      = active_ff ? unit_pos : '0;
               new_left_in = '0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         el_ff        <= '0;
         er_ff        <= '0;
         es_ff        <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         el_ff        <= el_in;
         er_ff        <= er_in;
         es_ff        <= es_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         l_ff     <= req_left_sample;
         r_ff     <= req_right_sample;
         band_ff  <= req_band_index;
         short_ff <= req_short_block;
         last_ff  <= req_last_line;
      end
      if (out_load) begin
         kind_ff     <= kind_in;
         used_ff     <= used_in;
         pos_ff      <= pos_in;
         new_left_ff <= new_left_in;
      end
   end

   // Band end units.
   isbe_gain #(
      .FRAC_BITS (GAIN_FRACTION_BITS)
   ) u_gain (
      .clock       (clock),
      .reset       (reset),
      .start       (unit_start),
      .energy_left (el_ff),
      .energy_sum  (es_ff),
      .busy        (gain_busy),
      .gain        (gain)
   );

   isbe_pos u_pos (
      .clock        (clock),
      .reset        (reset),
      .start        (unit_start),
      .energy_left  (el_ff),
      .energy_right (er_ff),
      .busy         (pos_busy),
      .position     (unit_pos)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_is_used  = used_ff;
   assign rsp_position = $signed(pos_ff);
   assign rsp_new_left = $signed(new_left_ff);

   // The energies are cleared while the band end units run.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BAND) |-> (el_ff == '0 && er_ff == '0 && es_ff == '0))
      else $error("energies not cleared at band end");

   // A position is reported only on a decision result for an intensity stereo band.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (kind_ff || !used_ff)) |-> (pos_ff == '0))
      else $error("position reported without intensity stereo decision");

   // A decision result carries no replaced line.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !kind_ff) |-> (new_left_ff == '0))
      else $error("decision result carries a line value");

   // The band end units are quiet whenever the sequencer is idle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!gain_busy && !pos_busy))
      else $error("band end unit busy while idle");

   // Measure lines that do not end a band never load a result.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQ) |-> !out_load)
      else $error("result issued during accumulation");

endmodule

FILE: tb/sv/isbe_band_checker.sv
// Checker for the intensity stereo band encoder: band predictor and result comparison.
`timescale 1ns / 1ps
module isbe_band_checker import isbe_pkg::*; #(
   parameter int SAMPLE_BITS        = 24,
   parameter int GAIN_FRACTION_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          req_mode,
   input  logic signed [SAMPLE_BITS-1:0] req_left_sample,
   input  logic signed [SAMPLE_BITS-1:0] req_right_sample,
   input  logic [BAND_W-1:0]             req_band_index,
   input  logic                          req_short_block,
   input  logic                          req_last_line,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic                          rsp_kind,
   input  logic                          rsp_is_used,
   input  logic signed [POS_W-1:0]       rsp_position,
   input  logic signed [SAMPLE_BITS-1:0] rsp_new_left,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic                          csr_pready,
   input  logic [2:0]                    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output int                            fail_count,
   output int                            pending_count,
   output int                            decision_count,
   output int                            line_count
);

   typedef struct packed {
      logic                          kind;
      logic                          is_used;
      logic signed [POS_W-1:0]       position;
      logic signed [SAMPLE_BITS-1:0] new_left;
   } band_result_type;

   band_result_type expected_results[$];

   // Shadow copy of the band state and the minimum band registers.
   logic [5:0]          min_long;
   logic [3:0]          min_short;
   logic [ENERGY_W-1:0] sum_left, sum_right, sum_both;
   logic [GAIN_W-1:0]   gain;
   logic                active;

   function automatic logic [63:0] sat_accumulate(logic [63:0] acc, logic [63:0] sq);
      logic [64:0] total;
      total = {1'b0, acc} + {1'b0, sq};
      return total[64] ? '1 : total[63:0];
   endfunction

   function automatic int leading_zeros(logic [63:0] v);
      int n;
      n = 0;
      while (!v[63]) begin
         v = v << 1;
         n++;
      end
      return n;
   endfunction

   // Largest gain g with g*g*(Es+1) <= El * 2^(2*fraction bits).
   function automatic logic [31:0] band_gain_of(logic [63:0] el, logic [63:0] es);
      logic [159:0] rhs, den, lhs;
      logic [63:0]  sq;
      logic [31:0]  g, c;
      rhs = {96'b0, el} << (2 * GAIN_FRACTION_BITS);
      den = {96'b0, es} + 160'd1;
      g = '0;
      for (int b = 31; b >= 0; b--) begin
         c = g | (32'd1 << b);
         sq = {32'b0, c} * {32'b0, c};
         lhs = {96'b0, sq} * den;
         if (lhs <= rhs) g = c;
      end
      return g;
   endfunction

   // Rounded twice log2 of the energy ratio, by exact compares of fourth powers.
   function automatic int position_of(logic [63:0] el, logic [63:0] er);
      logic [263:0] l2, r2, l4, r4;
      int lzl, lzr, j, p;
      if (el == 0 && er == 0) return 0;
      if (er == 0) return 127;
      if (el == 0) return -128;
      lzl = leading_zeros(el);
      lzr = leading_zeros(er);
      l2 = {200'b0, el << lzl} * {200'b0, el << lzl};
      r2 = {200'b0, er << lzr} * {200'b0, er << lzr};
      l4 = l2 * l2;
      r4 = r2 * r2;
      j = -2;
      if ((l4 << 3) >= r4) j++;
      if ((l4 << 1) >= r4) j++;
      if (l4 >= (r4 << 1)) j++;
      if (l4 >= (r4 << 3)) j++;
      p = 2 * (lzr - lzl) + j;
      if (p > 127) p = 127;
      if (p < -128) p = -128;
      return p;
   endfunction

   function automatic logic [63:0] magnitude_of(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   // Works out the result of one accepted request and updates the shadow state.
   task automatic predict_request();
      longint          l, r, s, nl;
      logic [63:0]     ms, mag, ss;
      longint          pmax;
      band_result_type res;
      l = req_left_sample;
      r = req_right_sample;
      s = l + r;
      ms = magnitude_of(s);
      pmax = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
      res = '0;
      if (req_mode) begin
         nl = l;
         if (active) begin
            mag = ms * {32'b0, gain};
            mag = (mag + (64'd1 << (GAIN_FRACTION_BITS - 1))) >> GAIN_FRACTION_BITS;
            if (s < 0) nl = (mag > 64'(pmax + 1)) ? -(pmax + 1) : -longint'(mag);
            else       nl = (mag > 64'(pmax)) ? pmax : longint'(mag);
         end
         res.kind = 1'b1;
         res.is_used = active;
         res.new_left = nl[SAMPLE_BITS-1:0];
         expected_results.push_back(res);
      end else begin
         // A sum of 2^32 or more squares past 64 bits and saturates.
         ss = (ms[63:32] != '0) ? '1 : ms * ms;
         sum_left  = sat_accumulate(sum_left, magnitude_of(l) * magnitude_of(l));
         sum_right = sat_accumulate(sum_right, magnitude_of(r) * magnitude_of(r));
         sum_both  = sat_accumulate(sum_both, ss);
         if (req_last_line) begin
            active = req_band_index >= (req_short_block ? {2'b0, min_short} : min_long);
            gain = band_gain_of(sum_left, sum_both);
            res.kind = 1'b0;
            res.is_used = active;
            res.position = active ? POS_W'(position_of(sum_left, sum_right)) : '0;
            sum_left = '0;
            sum_right = '0;
            sum_both = '0;
            expected_results.push_back(res);
         end
      end
   endtask

   task automatic compare_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      decision_count = 0;
      line_count = 0;
   end

   always @(posedge clock) begin
      band_result_type want;
      if (reset) begin
         min_long = MIN_BAND_LONG_RESET;
         min_short = MIN_BAND_SHORT_RESET;
         sum_left = '0;
         sum_right = '0;
         sum_both = '0;
         gain = '0;
         active = 1'b0;
         expected_results.delete();
      end else begin
         // Register writes.
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == CSR_MIN_BAND_SHORT) min_short = csr_pwdata[3:0];
            else                                    min_long = csr_pwdata[5:0];
         end
         // Accepted request.
         if (req_valid && !req_stall) predict_request();
         // Accepted result.
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("result arrived with no expectation waiting");
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               compare_field("kind", want.kind, rsp_kind);
               compare_field("is_used", want.is_used, rsp_is_used);
               compare_field("position", want.position, rsp_position);
               compare_field("new_left", want.new_left, rsp_new_left);
               if (want.kind) line_count++;
               else decision_count++;
            end
         end
      end
      pending_count = expected_results.size();
   end

endmodule

FILE: tb/sv/tb_intensity_stereo_band_encoder.sv
// Testbench top for the intensity stereo band encoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_intensity_stereo_band_encoder;
   import isbe_pkg::*;

   localparam int SAMPLE_BITS  = 24;
   localparam int CYCLE_LIMIT  = 1500000;
   localparam int SETTLE_TICKS = 250;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_mode = 1'b0;
   logic signed [SAMPLE_BITS-1:0] req_left_sample = '0;
   logic signed [SAMPLE_BITS-1:0] req_right_sample = '0;
   logic [BAND_W-1:0]             req_band_index = '0;
   logic                          req_short_block = 1'b0;
   logic                          req_last_line = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_kind;
   logic                          rsp_is_used;
   logic signed [POS_W-1:0]       rsp_position;
   logic signed [SAMPLE_BITS-1:0] rsp_new_left;
   logic                          csr_psel = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite = 1'b0;
   logic [2:0]                    csr_paddr = '0;
   logic [31:0]                   csr_pwdata = '0;
   logic [31:0]                   csr_prdata;
   logic                          csr_pready;

   int fail_count, pending_count, decision_count, line_count;
   int tx_idle_pct = 0, rx_idle_pct = 0;
   int request_count = 0;
   int cycle_count = 0;
   bit long_hold_go = 1'b0;
   bit long_hold_done = 1'b0;
   int hold_left = 0;

   intensity_stereo_band_encoder dut (.*);

   isbe_band_checker checker_i (.*);

   always #5 clock = ~clock;

   // Receiver stall: random, plus one long hold-off on request.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (long_hold_go && !long_hold_done && hold_left == 0) begin
         hold_left <= 400;
         long_hold_done <= 1'b1;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   // Timeout guard.
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Offers one request and waits until it is accepted.
   task automatic send_line(bit mode, logic [23:0] l, logic [23:0] r,
                            logic [5:0] band, bit shrt, bit last);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_left_sample <= l;
      req_right_sample <= r;
      req_band_index <= band;
      req_short_block <= shrt;
      req_last_line <= last;
      do @(posedge clock); while (req_stall);
      request_count++;
   endtask

   // Writes both minimum band registers once the block is idle.
   task automatic write_minimums(logic [5:0] long_min, logic [3:0] short_min);
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
      for (int i = 0; i < 2; i++) begin
         csr_psel <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b1;
         csr_paddr <= (i == 0) ? 3'd0 : 3'd4;
         csr_pwdata <= (i == 0) ? {26'b0, long_min} : {28'b0, short_min};
         @(posedge clock);
         csr_penable <= 1'b1;
         @(posedge clock);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   function automatic logic [23:0] random_sample(int style);
      case (style)
         0: return 24'($urandom);
         1: return 24'($urandom_range(0, 255)) - 24'd128;
         2: return ($urandom_range(1)) ? 24'h7FFFFF : 24'h800000;
         default: return 24'($signed(24'($urandom)) >>> $urandom_range(0, 20));
      endcase
   endfunction

   // One band: measure lines ending in a last line, then apply lines.
   task automatic send_band(int max_lines);
      logic [5:0]  band;
      bit          shrt;
      int          n, style, shape;
      logic [23:0] l, r;
      band = $urandom_range(0, 63);
      shrt = $urandom_range(1);
      if (shrt) band = $urandom_range(0, 15);
      n = $urandom_range(1, max_lines);
      style = $urandom_range(0, 3);
      shape = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) begin
         l = random_sample(style);
         r = random_sample(style);
         if (shape == 1) r = l;
         if (shape == 2) r = -l;
         if (shape == 3) r = $urandom_range(1) ? 24'd0 : r;
         send_line(1'b0, l, r, band, shrt, i == n - 1);
      end
      n = $urandom_range(0, max_lines);
      for (int i = 0; i < n; i++)
         send_line(1'b1, random_sample(style), random_sample(style),
                   6'($urandom), $urandom_range(1), $urandom_range(1));
   endtask

   task automatic random_phase(int count);
      int start;
      start = request_count;
      while (request_count - start < count) begin
         if ($urandom_range(9) == 0)
            send_line($urandom_range(1), random_sample(0), random_sample(0),
                      6'($urandom), $urandom_range(1), $urandom_range(1));
         else
            send_band(6);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset thresholds, extremes, zero energies, saturation.
      send_line(1'b1, 24'h7FFFFF, 24'h000001, 6'd63, 1'b0, 1'b0);
      send_line(1'b0, 24'h7FFFFF, 24'h800000, 6'd63, 1'b0, 1'b1);
      send_line(1'b1, 24'h7FFFFF, 24'h7FFFFF, 6'd0, 1'b0, 1'b0);
      send_line(1'b0, 24'h123456, 24'h000000, 6'd28, 1'b0, 1'b1);
      send_line(1'b0, 24'h000000, 24'h000005, 6'd28, 1'b0, 1'b1);
      send_line(1'b0, 24'h000000, 24'h000000, 6'd8, 1'b1, 1'b1);
      send_line(1'b0, 24'h7FFFFF, 24'h800001, 6'd8, 1'b1, 1'b1);
      send_line(1'b1, 24'h7FFFFF, 24'h7FFFFF, 6'd0, 1'b0, 1'b0);
      send_line(1'b1, 24'h800000, 24'h800000, 6'd0, 1'b0, 1'b0);
      send_line(1'b0, 24'h000100, 24'h000080, 6'd27, 1'b0, 1'b1);
      send_line(1'b1, 24'h000100, 24'h000080, 6'd27, 1'b0, 1'b1);
      send_line(1'b0, 24'h000300, 24'h000100, 6'd7, 1'b1, 1'b0);
      send_line(1'b0, 24'h800000, 24'h7FFFFF, 6'd7, 1'b1, 1'b1);
      send_line(1'b0, 24'h000400, 24'h000100, 6'd63, 1'b1, 1'b1);
      send_line(1'b1, 24'h000400, 24'h000100, 6'd0, 1'b1, 1'b1);
      send_line(1'b1, 24'hFFFC00, 24'hFFFF00, 6'd0, 1'b1, 1'b1);

      // Random phases under different thresholds and idling.
      write_minimums(6'd63, 4'd15);
      tx_idle_pct = 21;
      rx_idle_pct = 66;
      random_phase(100);
      write_minimums(6'd0, 4'd0);
      tx_idle_pct = 66;
      rx_idle_pct = 21;
      random_phase(100);
      write_minimums(6'($urandom_range(1, 62)), 4'($urandom_range(1, 14)));
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      long_hold_go = 1'b1;
      random_phase(100);
      write_minimums(6'd20, 4'd4);
      random_phase(100);
      req_valid <= 1'b0;

      // Drain and settle.
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
      $display("Covered %0d requests: %0d band decisions and %0d replaced lines checked,",
               request_count, decision_count, line_count);
      $display("under four threshold settings, random stalls and one long output hold-off.");
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
